// ===== hdl/rsm_pkg.sv =====
package rsm_pkg;

   localparam int PATTERN_MAX_DEF = 16;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 64;
   localparam int CHARS_W         = 64;
   localparam int MASK_W          = 16;
   localparam int LEN_REG_W       = 5;
   localparam int BYTE_W          = 8;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_CHARS_LOW    = 3'd0;
   localparam csr_idx_type REG_CHARS_HIGH   = 3'd1;
   localparam csr_idx_type REG_ANY_MASK     = 3'd2;
   localparam csr_idx_type REG_STAR_MASK    = 3'd3;
   localparam csr_idx_type REG_PATTERN_LEN  = 3'd4;
   localparam csr_idx_type REG_ANCHOR_START = 3'd5;
   localparam csr_idx_type REG_ANCHOR_END   = 3'd6;

   localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

   typedef struct packed {
      logic inject;
      logic anchor_end;
   } ctrl_type;

   typedef struct packed {
      logic hit;
      logic done;
   } status_type;

endpackage

// ===== hdl/rsm_core.sv =====
module rsm_core #(
   parameter int PATTERN_MAX = rsm_pkg::PATTERN_MAX_DEF,
   parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
   input  logic [PATTERN_MAX:0]               active,
   input  logic [rsm_pkg::BYTE_W-1:0]         text_byte,
   input  logic [rsm_pkg::BYTE_W*PATTERN_MAX-1:0] chars,
   input  logic [PATTERN_MAX-1:0]             any_mask,
   input  logic [PATTERN_MAX-1:0]             star_mask,
   input  logic [LEN_W-1:0]                   len,
   input  rsm_pkg::ctrl_type                  ctrl,
   output logic [PATTERN_MAX:0]               next_active,
   output rsm_pkg::status_type                status
);
   import rsm_pkg::*;

   logic [PATTERN_MAX:0]   cur;
   logic [PATTERN_MAX:0]   clo;
   logic [PATTERN_MAX-1:0] in_use;
   logic [PATTERN_MAX-1:0] star_act;
   logic [PATTERN_MAX-1:0] elem_hit;
   logic                   done;

   assign done = (text_byte == TERMINATOR);

   // positions beyond the pattern length are dropped, then inject starts a new attempt at position 0
   always_comb begin
      for (int j = 0; j <= PATTERN_MAX; j++) begin
         cur[j] = active[j] & (j <= int'(len));
      end
      cur[0] = cur[0] | ctrl.inject;
   end

   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         in_use[k]   = (k < int'(len));
         star_act[k] = star_mask[k] & in_use[k];
         elem_hit[k] = !done && (any_mask[k] ||
                       (chars[BYTE_W*k +: BYTE_W] == text_byte));
      end
   end

   // star closure: position j is reached from any active i at or below it
   // when every element from i to j-1 is starred
   always_comb begin
      logic run;
      run = 1'b1;
      for (int j = 0; j <= PATTERN_MAX; j++) begin
         clo[j] = 1'b0;
         run    = 1'b1;
         for (int i = j; i >= 0; i--) begin
            clo[j] = clo[j] | (cur[i] & run);
            if (i > 0) begin
               run = run & star_act[i-1];
            end
         end
      end
   end

   always_comb begin
      next_active = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (in_use[k] && clo[k] && elem_hit[k]) begin
            if (star_mask[k]) begin
               next_active[k] = 1'b1;
            end else begin
               next_active[k+1] = 1'b1;
            end
         end
      end
   end

   assign status.hit  = clo[len] & (!ctrl.anchor_end | done);
   assign status.done = done;

endmodule

// ===== hdl/regex_stream_matcher.sv =====
// A req word goes into the input register, its result into the result
// register. Throughput: one text word per cycle unless a held rsp word
// stalls the output; the star closure and the NFA step sit in one stage
// between the input register and the result register.
// Reset (synchronous, active high): no words held, config registers zero,
// no positions active, match flag clear, at start of string.
module regex_stream_matcher #(
   parameter int PATTERN_MAX = rsm_pkg::PATTERN_MAX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rsm_pkg::BYTE_W-1:0]         req_text_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_matched,
   output logic                               rsp_done_res,
   input  logic                               csr_we,
   input  rsm_pkg::csr_idx_type               csr_index,
   input  logic [rsm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rsm_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   logic [CHARS_W-1:0]   chars_low_ff;
   logic [CHARS_W-1:0]   chars_high_ff;
   logic [MASK_W-1:0]    any_mask_ff;
   logic [MASK_W-1:0]    star_mask_ff;
   logic [LEN_REG_W-1:0] pattern_len_ff;
   logic                 anchor_start_ff;
   logic                 anchor_end_ff;

   logic [PATTERN_MAX:0] active_ff;
   logic [PATTERN_MAX:0] active_in;
   logic                 found_ff;
   logic                 start_ff;

   logic                 in_valid_ff;
   logic [BYTE_W-1:0]    in_byte_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_matched_ff;
   logic                 rsp_done_ff;

   logic [2*CHARS_W-1:0] chars_all;
   logic [LEN_W-1:0]     len;
   logic                 advance;
   logic                 out_free;
   logic                 matched_in;
   ctrl_type             ctrl;
   status_type           status;

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_low_ff    <= '0;
         chars_high_ff   <= '0;
         any_mask_ff     <= '0;
         star_mask_ff    <= '0;
         pattern_len_ff  <= '0;
         anchor_start_ff <= 1'b0;
         anchor_end_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CHARS_LOW:    chars_low_ff    <= csr_wdata[CHARS_W-1:0];
            REG_CHARS_HIGH:   chars_high_ff   <= csr_wdata[CHARS_W-1:0];
            REG_ANY_MASK:     any_mask_ff     <= csr_wdata[MASK_W-1:0];
            REG_STAR_MASK:    star_mask_ff    <= csr_wdata[MASK_W-1:0];
            REG_PATTERN_LEN:  pattern_len_ff  <= csr_wdata[LEN_REG_W-1:0];
            REG_ANCHOR_START: anchor_start_ff <= csr_wdata[0];
            REG_ANCHOR_END:   anchor_end_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign chars_all = {chars_high_ff, chars_low_ff};

   always_comb begin
      if (int'(pattern_len_ff) > PATTERN_MAX) begin
         len = LEN_W'(PATTERN_MAX);
      end else begin
         len = LEN_W'(pattern_len_ff);
      end
   end

   assign ctrl.inject     = start_ff | ~anchor_start_ff;
   assign ctrl.anchor_end = anchor_end_ff;

   rsm_core #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W)
   ) u_core (
      .active      (active_ff),
      .text_byte   (in_byte_ff),
      .chars       (chars_all[BYTE_W*PATTERN_MAX-1:0]),
      .any_mask    (any_mask_ff[PATTERN_MAX-1:0]),
      .star_mask   (star_mask_ff[PATTERN_MAX-1:0]),
      .len         (len),
      .ctrl        (ctrl),
      .next_active (active_in),
      .status      (status)
   );

   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign advance    = in_valid_ff & out_free;
   assign req_ready  = ~in_valid_ff | advance;
   assign matched_in = found_ff | status.hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         found_ff  <= 1'b0;
         start_ff  <= 1'b1;
      end else if (advance) begin
         if (status.done) begin
            active_ff <= '0;
            found_ff  <= 1'b0;
            start_ff  <= 1'b1;
         end else begin
            active_ff <= active_in;
            found_ff  <= matched_in;
            start_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_matched_ff <= matched_in;
         rsp_done_ff    <= status.done;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_matched  = rsp_matched_ff;
   assign rsp_done_res = rsp_done_ff;

`ifndef SYNTHESIS
   a_end_of_string_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && status.done) |=> (start_ff && !found_ff && active_ff == '0))
      else $error("string state not cleared after terminator word");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled while a register was free");

   a_start_drops_after_byte: assert property (@(posedge clock) disable iff (reset)
      (advance && !status.done) |=> !start_ff)
      else $error("start flag kept after a text word");
`endif

endmodule
